// ===== design/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

  // Heap store size and the address width it needs.
  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  // One command word from the front to the heap engine.
  typedef struct packed {
    logic             op;
    logic signed [31:0] value;
  } cmd_t;

  // One result word from the heap engine.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] max_value;
    logic [10:0]        occupancy;
  } res_t;

endpackage

// ===== design/mhpq_cmd_fifo.sv =====
// Two-entry command queue between the input side and the heap engine.
module mhpq_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mhpq_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output mhpq_pkg::cmd_t pop_data,
  output logic          empty
);
  import mhpq_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end
endmodule

// ===== design/mhpq_engine.sv =====
// Heap engine: runs sift-up and sift-down over a memory with one read port and one write port.
module mhpq_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [10:0]    cap_limit,
  input  logic           cmd_valid,
  input  mhpq_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           res_valid,
  output mhpq_pkg::res_t res,
  input  logic           res_take
);
  import mhpq_pkg::*;

  localparam int CW = AW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UPRD  = 9'b000000010,
    S_UPCMP = 9'b000000100,
    S_LRD   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_DNL   = 9'b000100000,
    S_DNR   = 9'b001000000,
    S_DNCMP = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_r;
  logic [AW-1:0]      raddr;
  logic               wen;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] lv_r, lv_nxt;
  logic               lok_r, lok_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;
  logic               rv_r, rv_nxt;

  logic [CW-1:0] limit, up_idx, lc, rc;
  logic [CW:0]   lc_w;

  assign limit  = (cap_limit < CW'(DEPTH)) ? cap_limit[CW-1:0] : CW'(DEPTH);
  assign up_idx = (pos_r - CW'(1)) >> 1;
  assign lc_w   = {pos_r, 1'b1};
  assign lc     = lc_w[CW-1:0];
  assign rc     = lc + CW'(1);

  // Memory with registered read data.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // The output register holds a finished word, so the next command can run meanwhile.
  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = rv_r;
  assign res       = out_r;

  // Sequencer for one command.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    lv_nxt    = lv_r;
    lok_nxt   = lok_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    rv_nxt    = rv_r && !res_take;
    raddr     = '0;
    wen       = 1'b0;
    waddr     = pos_r[AW-1:0];
    wdata     = key_r;
    unique case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (cmd_take) begin
          res_nxt.max_value = '0;
          if (cmd.op == OP_INSERT) begin
            if (cnt_r >= limit) begin
              res_nxt.status    = ST_FULL;
              res_nxt.occupancy = 11'(cnt_r);
              state_nxt         = S_DONE;
            end else begin
              res_nxt.status = ST_INSERTED;
              key_nxt        = cmd.value;
              pos_nxt        = cnt_r;
              cnt_nxt        = cnt_r + CW'(1);
              state_nxt      = S_UPRD;
            end
          end else if (cnt_r == '0) begin
            res_nxt.status    = ST_EMPTY;
            res_nxt.max_value = EMPTY_VALUE;
            res_nxt.occupancy = '0;
            state_nxt         = S_DONE;
          end else begin
            res_nxt.status = ST_EXTRACTED;
            cnt_nxt        = cnt_r - CW'(1);
            state_nxt      = S_LRD;
          end
        end
      end
      // Sift up: read parent, then compare and move it down.
      S_UPRD: begin
        if (pos_r == '0) begin
          wen       = 1'b1;
          state_nxt = S_DONE;
          res_nxt.occupancy = 11'(cnt_r);
        end else begin
          raddr     = up_idx[AW-1:0];
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (key_r > rd_r) begin
          wen       = 1'b1;
          wdata     = rd_r;
          pos_nxt   = up_idx;
          state_nxt = S_UPRD;
        end else begin
          wen       = 1'b1;
          state_nxt = S_DONE;
          res_nxt.occupancy = 11'(cnt_r);
        end
      end
      // Extract: read last entry (root read issued earlier).
      S_LRD: begin
        raddr     = cnt_r[AW-1:0];
        res_nxt.max_value = rd_r;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        key_nxt   = rd_r;
        pos_nxt   = '0;
        state_nxt = S_DNL;
        res_nxt.occupancy = 11'(cnt_r);
      end
      // Sift down: read left child, then right child, then decide.
      S_DNL: begin
        raddr = lc[AW-1:0];
        if (lc_w >= {1'b0, cnt_r}) begin
          wen       = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        raddr     = rc[AW-1:0];
        lv_nxt    = rd_r;
        lok_nxt   = rd_r > key_r;
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (rc < cnt_r && rd_r > (lok_r ? lv_r : key_r)) begin
          wen       = 1'b1;
          wdata     = rd_r;
          pos_nxt   = rc;
          state_nxt = S_DNL;
        end else if (lok_r) begin
          wen       = 1'b1;
          wdata     = lv_r;
          pos_nxt   = lc;
          state_nxt = S_DNL;
        end else begin
          wen       = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // Hand the word to the output register once it is free.
      S_DONE: begin
        if (!rv_r || res_take) begin
          rv_nxt    = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
    end
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    lv_r  <= lv_nxt;
    lok_r <= lok_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end
endmodule

// ===== design/max_heap_priority_queue.sv =====
// Max-heap priority queue top level: command queue, heap engine, result register.
// An insert sifts the new key up from the last slot; an extract moves the last entry to the
// root and sifts it down. The engine runs one command at a time; the two-entry command queue
// accepts further words while it is busy. The sift-down loop over the heap memory is the
// slowest part of the engine.
// Synchronous active-low reset empties the heap and sets the capacity limit to 1024.
module max_heap_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic               in_operation,
  input  logic signed [31:0] in_value,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_max_value,
  output logic [10:0]        out_occupancy
);
  import mhpq_pkg::*;

  logic [10:0] cap_r;
  cmd_t        in_cmd, q_cmd;
  logic        q_empty, q_take;
  res_t        res;
  logic        rv;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 11'd1024;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign in_cmd.op    = in_operation;
  assign in_cmd.value = in_value;

  mhpq_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(in_cmd), .full(full),
    .pop(q_take), .pop_data(q_cmd), .empty(q_empty)
  );

  mhpq_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cap_limit(cap_r),
    .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
    .res_valid(rv), .res(res), .res_take(pop)
  );

  assign empty         = !rv;
  assign out_status    = res.status;
  assign out_max_value = res.max_value;
  assign out_occupancy = res.occupancy;

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_occupancy <= 11'(DEPTH)) else $error("occupancy over depth");
  a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_EMPTY) |-> (out_max_value == EMPTY_VALUE && out_occupancy == 0))
    else $error("bad empty result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable({out_status, out_max_value, out_occupancy})))
    else $error("waiting word changed");
`endif
endmodule

// ===== tb/mhpq_checker.sv =====
// Checker for the max-heap priority queue: predicts each result word and compares it.
module mhpq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               push,
  input  logic               full,
  input  logic               in_operation,
  input  logic signed [31:0] in_value,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_max_value,
  input  logic [10:0]        out_occupancy,
  output int                 fail_count,
  output int                 pending_words
);
  import mhpq_pkg::*;

  // Shadow heap and its configuration.
  logic signed [31:0] shadow_heap [DEPTH];
  int                 shadow_count;
  logic [10:0]        shadow_limit;
  res_t               expected_words [$];

  assign pending_words = expected_words.size();

  // Apply one command word to the shadow heap and return the result it yields.
  function automatic res_t heap_apply(logic op, logic signed [31:0] val);
    res_t r;
    int   pos;
    int   up;
    int   lc;
    int   rc;
    int   best;
    int   lim;
    logic signed [31:0] tmp;
    r = '0;
    if (op == OP_INSERT) begin
      lim = (shadow_limit < DEPTH) ? int'(shadow_limit) : DEPTH;
      if (shadow_count >= lim) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_heap[pos] = val;
        shadow_count++;
        // Sift up; stop at an equal parent.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_heap[pos] > shadow_heap[up]) begin
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[up];
            shadow_heap[up] = tmp;
            pos = up;
          end else begin
            break;
          end
        end
        r.status = ST_INSERTED;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
      r.max_value = EMPTY_VALUE;
    end else begin
      r.status = ST_EXTRACTED;
      r.max_value = shadow_heap[0];
      shadow_heap[0] = shadow_heap[shadow_count - 1];
      shadow_count--;
      // Sift down; move only to a strictly greater child, left first.
      pos = 0;
      forever begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        best = pos;
        if (lc < shadow_count && shadow_heap[lc] > shadow_heap[best]) best = lc;
        if (rc < shadow_count && shadow_heap[rc] > shadow_heap[best]) best = rc;
        if (best == pos) break;
        tmp = shadow_heap[pos];
        shadow_heap[pos] = shadow_heap[best];
        shadow_heap[best] = tmp;
        pos = best;
      end
    end
    r.occupancy = shadow_count[10:0];
    return r;
  endfunction

  // Watch both channels and the configuration port on every edge.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_limit = 11'd1024;
      fail_count   <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) shadow_limit = cfg_wdata;
      if (push && !full) expected_words.push_back(heap_apply(in_operation, in_value));
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word status=%0d max=%0d occ=%0d", $time,
                   out_status, out_max_value, out_occupancy);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.status !== out_status || want.max_value !== out_max_value ||
              want.occupancy !== out_occupancy) begin
            $display("%0t: mismatch expected status=%0d max=%0d occ=%0d, actual %0d %0d %0d",
                     $time, want.status, want.max_value, want.occupancy,
                     out_status, out_max_value, out_occupancy);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_max_heap_priority_queue.sv =====
// Testbench top for the max-heap priority queue: stimulus, configuration and verdict.
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [10:0]        cfg_wdata;
  logic               push;
  logic               full;
  logic               in_operation;
  logic signed [31:0] in_value;
  logic               empty;
  logic               pop;
  logic [1:0]         out_status;
  logic signed [31:0] out_max_value;
  logic [10:0]        out_occupancy;
  int                 fail_count;
  int                 pending_words;
  int                 cycle_count;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  max_heap_priority_queue dut (.*);

  mhpq_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: pop stalls at random.
  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one command word, idling first at random, and wait for acceptance.
  // Push stays high after acceptance; the next idle cycle or drain lowers it.
  task automatic send_word(logic op, logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    in_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Wait until every result has arrived, then let the engine settle.
  task automatic drain();
    push <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [10:0] lim);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random value, sometimes from a narrow range so equal keys occur.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $signed($urandom_range(7)) - 4;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    cycle_count = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    push = 1'b0;
    in_operation = OP_INSERT;
    in_value = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty extract, extremes, equal keys, small limit, zero limit.
    send_word(OP_EXTRACT, 32'sd5);
    send_word(OP_INSERT, 32'sh7fffffff);
    send_word(OP_INSERT, 32'sh80000000);
    send_word(OP_INSERT, 32'sd3);
    send_word(OP_INSERT, 32'sd3);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd3);
    repeat (7) send_word(OP_EXTRACT, 32'sh5555aaaa);
    drain();
    write_limit(11'd2);
    repeat (4) send_word(OP_INSERT, 32'sd9);
    drain();
    write_limit(11'd1);
    send_word(OP_INSERT, 32'sd1);
    send_word(OP_EXTRACT, 32'sd0);
    send_word(OP_EXTRACT, 32'sd0);
    drain();
    write_limit(11'd0);
    send_word(OP_INSERT, 32'sd7);
    send_word(OP_EXTRACT, 32'sd0);
    drain();

    // Random phases under different limits and idling patterns.
    for (phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 34; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: write_limit(11'd5);
        1: write_limit(11'd2047);
        2: write_limit(11'd1024);
        3: write_limit(11'd16);
        4: write_limit(11'd1023);
        default: write_limit(11'($urandom_range(1, 40)));
      endcase
      for (n = 0; n < 95; n++)
        send_word(($urandom_range(99) < 55) ? OP_INSERT : OP_EXTRACT, pick_value());
      drain();
    end

    // Lower the limit below the occupancy, then run extracts on the heap.
    write_limit(11'd40);
    repeat (30) send_word(OP_INSERT, pick_value());
    drain();
    write_limit(11'd3);
    repeat (3) send_word(OP_INSERT, pick_value());
    repeat (31) send_word(OP_EXTRACT, pick_value());
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== max_heap_priority_queue.f =====
design/mhpq_pkg.sv
design/mhpq_cmd_fifo.sv
design/mhpq_engine.sv
design/max_heap_priority_queue.sv
tb/mhpq_checker.sv
tb/tb_max_heap_priority_queue.sv
